>>> hdl/pod_pkg.sv
`default_nettype none

package pod_pkg;

  localparam logic [1:0] CSEL_MAGIC  = 2'd0;
  localparam logic [1:0] CSEL_BAYER  = 2'd1;
  localparam logic [1:0] CSEL_RANDOM = 2'd2;
  localparam logic [1:0] CSEL_NONE   = 2'd3;

  localparam logic [1:0] ASEL_MATRIX = 2'd0;
  localparam logic [1:0] ASEL_INVERT = 2'd1;
  localparam logic [1:0] ASEL_RANDOM = 2'd2;
  localparam logic [1:0] ASEL_ZERO   = 2'd3;

  localparam logic [3:0] MODE_RESET      = 4'hf;
  localparam logic [8:0] NO_DITHER_VALUE = 9'd7;
  localparam logic       REG_DITHER_MODE = 1'b0;

  typedef struct packed {
    logic [1:0] x;
    logic [1:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [8:0] rnd_c;
    logic [2:0] rnd_a;
  } pod_pix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [2:0] rt;
    logic [2:0] gt;
    logic [2:0] bt;
    logic [8:0] cd;
    logic [2:0] ad;
  } pod_thr_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [8:0] cd;
    logic [2:0] ad;
  } pod_res_t;

  function automatic logic [2:0] magic_entry(input logic [3:0] idx);
    logic [2:0] v;
    case (idx)
      4'd0:  v = 3'd0;
      4'd1:  v = 3'd6;
      4'd2:  v = 3'd1;
      4'd3:  v = 3'd7;
      4'd4:  v = 3'd4;
      4'd5:  v = 3'd2;
      4'd6:  v = 3'd5;
      4'd7:  v = 3'd3;
      4'd8:  v = 3'd3;
      4'd9:  v = 3'd5;
      4'd10: v = 3'd2;
      4'd11: v = 3'd4;
      4'd12: v = 3'd7;
      4'd13: v = 3'd1;
      4'd14: v = 3'd6;
      4'd15: v = 3'd0;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] bayer_entry(input logic [3:0] idx);
    logic [2:0] v;
    case (idx)
      4'd0:  v = 3'd0;
      4'd1:  v = 3'd4;
      4'd2:  v = 3'd1;
      4'd3:  v = 3'd5;
      4'd4:  v = 3'd4;
      4'd5:  v = 3'd0;
      4'd6:  v = 3'd5;
      4'd7:  v = 3'd1;
      4'd8:  v = 3'd3;
      4'd9:  v = 3'd7;
      4'd10: v = 3'd2;
      4'd11: v = 3'd6;
      4'd12: v = 3'd7;
      4'd13: v = 3'd3;
      4'd14: v = 3'd6;
      4'd15: v = 3'd2;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pixel_ordered_dither_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    pixel_x pixel_y red/green/blue_in random_*
// out      output     out_valid / out_stall  red/green/blue_out color/alpha_dither_value
// cfg      input      APB, pready tied high  dither_mode at address 0
//
// Three register stages: input capture, dither select, round. One item per cycle
// sustained while out_stall is low; rate is set by the per-stage registers.
// Each stage moves when the stage after it is empty or moving, so bubbles fill
// under out_stall and in_stall rises only when all three stages hold items.
// Synchronous reset empties the pipe and sets dither_mode to 15.
`default_nettype none

module pixel_ordered_dither_unit
  import pod_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_pixel_x,
  input  wire logic [1:0] in_pixel_y,
  input  wire logic [7:0] in_red_in,
  input  wire logic [7:0] in_green_in,
  input  wire logic [7:0] in_blue_in,
  input  wire logic [8:0] in_random_color,
  input  wire logic [2:0] in_random_alpha,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_red_out,
  output logic [7:0]      out_green_out,
  output logic [7:0]      out_blue_out,
  output logic [8:0]      out_color_dither_value,
  output logic [2:0]      out_alpha_dither_value,
  input  wire logic       cfg_psel,
  input  wire logic       cfg_penable,
  input  wire logic       cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  logic [3:0] mode_r;
  logic [3:0] mode_nxt;
  logic       cfg_wr;

  logic     va_r, vb_r, vc_r;
  logic     en_a, en_b, en_c;
  pod_pix_t pa_r;
  pod_thr_t tb_r;
  pod_res_t rc_r;
  pod_thr_t tb_nxt;
  pod_res_t rc_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mode_nxt   = (cfg_wr && cfg_paddr[2] == REG_DITHER_MODE) ? cfg_pwdata[3:0] : mode_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_DITHER_MODE) ? {28'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign en_c     = !vc_r || !out_stall;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_stall = !en_a;

  pod_sel u_sel (
    .mode (mode_r),
    .pix  (pa_r),
    .thr  (tb_nxt)
  );

  pod_round u_round (
    .thr (tb_r),
    .res (rc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pa_r.x     <= in_pixel_x;
      pa_r.y     <= in_pixel_y;
      pa_r.r     <= in_red_in;
      pa_r.g     <= in_green_in;
      pa_r.b     <= in_blue_in;
      pa_r.rnd_c <= in_random_color;
      pa_r.rnd_a <= in_random_alpha;
    end
    if (en_b) tb_r <= tb_nxt;
    if (en_c) rc_r <= rc_nxt;
  end

  assign out_valid              = vc_r;
  assign out_red_out            = rc_r.r;
  assign out_green_out          = rc_r.g;
  assign out_blue_out           = rc_r.b;
  assign out_color_dither_value = rc_r.cd;
  assign out_alpha_dither_value = rc_r.ad;

endmodule

`default_nettype wire

>>> hdl/pod_sel.sv
`default_nettype none

module pod_sel
  import pod_pkg::*;
(
  input  wire logic [3:0] mode,
  input  wire pod_pix_t   pix,
  output pod_thr_t        thr
);

  logic [1:0] csel;
  logic [1:0] asel;
  logic [3:0] idx;
  logic [2:0] mat;
  logic [8:0] cd;
  logic [2:0] ad;

  assign csel = mode[3:2];
  assign asel = mode[1:0];
  assign idx  = {pix.y, pix.x};
  assign mat  = csel[0] ? bayer_entry(idx) : magic_entry(idx);

  always_comb begin
    case (csel)
      CSEL_RANDOM: cd = pix.rnd_c;
      CSEL_NONE:   cd = NO_DITHER_VALUE;
      default:     cd = {6'd0, mat};
    endcase
    case (asel)
      ASEL_MATRIX: ad = mat;
      ASEL_INVERT: ad = ~mat;
      ASEL_RANDOM: ad = pix.rnd_a;
      ASEL_ZERO:   ad = 3'd0;
      default:     ad = 3'd0;
    endcase
  end

  always_comb begin
    thr.r  = pix.r;
    thr.g  = pix.g;
    thr.b  = pix.b;
    thr.cd = cd;
    thr.ad = ad;
    if (csel == CSEL_RANDOM) begin
      thr.rt = cd[2:0];
      thr.gt = cd[5:3];
      thr.bt = cd[8:6];
    end else begin
      thr.rt = cd[2:0];
      thr.gt = cd[2:0];
      thr.bt = cd[2:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/pod_round.sv
`default_nettype none

module pod_round
  import pod_pkg::*;
(
  input  wire pod_thr_t thr,
  output pod_res_t      res
);

  function automatic logic [7:0] dither_chan(input logic [7:0] c, input logic [2:0] t);
    logic [7:0] up;
    logic [4:0] hi;
    hi = c[7:3] + 5'd1;
    up = (c[7:3] == 5'h1f) ? 8'hff : {hi, 3'b000};
    return (c[2:0] > t) ? up : c;
  endfunction

  assign res.r  = dither_chan(thr.r, thr.rt);
  assign res.g  = dither_chan(thr.g, thr.gt);
  assign res.b  = dither_chan(thr.b, thr.bt);
  assign res.cd = thr.cd;
  assign res.ad = thr.ad;

endmodule

`default_nettype wire

>>> hdl/pod_checker.sv
`default_nettype none

module pod_checker
  import pod_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_red_out,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out))
    else $error("stalled item dropped or changed");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("item did not reach output in three cycles");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_DITHER_MODE |=>
    (cfg_paddr[2] != REG_DITHER_MODE) || (cfg_prdata[3:0] == $past(cfg_pwdata[3:0])))
    else $error("mode readback mismatch");

endmodule

bind pixel_ordered_dither_unit pod_checker u_pod_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_red_out (out_red_out),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

`default_nettype wire
